// ----- rtl/tea_pkg.sv -----
`default_nettype none

package tea_pkg;

    localparam int WORD_W    = 32;
    localparam int ROUNDS    = 32;
    localparam int STAGES    = 2 * ROUNDS;
    localparam int CFG_IDX_W = 3;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // register indexes on the configuration port
    localparam cfg_idx_t REG_ROUND_DELTA  = 3'd0;
    localparam cfg_idx_t REG_FIRST_KEY_A  = 3'd1;
    localparam cfg_idx_t REG_FIRST_KEY_B  = 3'd2;
    localparam cfg_idx_t REG_SECOND_KEY_A = 3'd3;
    localparam cfg_idx_t REG_SECOND_KEY_B = 3'd4;

    // op codes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // reset values
    localparam word_t RST_ROUND_DELTA  = 32'h45AD_9059;
    localparam word_t RST_FIRST_KEY_A  = 32'hF03E_934F;
    localparam word_t RST_FIRST_KEY_B  = 32'h27BD_B886;
    localparam word_t RST_SECOND_KEY_A = 32'hD0AA_E945;
    localparam word_t RST_SECOND_KEY_B = 32'h993B_A3AE;

    localparam logic [2*WORD_W-1:0] RST_DELTA_PRODUCT =
        (2*WORD_W)'(RST_ROUND_DELTA) * (2*WORD_W)'(ROUNDS);
    localparam word_t RST_DELTA_ROUNDS = RST_DELTA_PRODUCT[WORD_W-1:0];

    // feistel mixing term
    function automatic word_t mix(input word_t v, input word_t sum,
                                  input word_t ka, input word_t kb);
        word_t t1;
        word_t t2;
        word_t t3;
        t1 = kb + (v << 4);
        t2 = ka + (v >> 5);
        t3 = sum + v;
        return t1 ^ t2 ^ t3;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tea_in_if.sv -----
`default_nettype none

interface tea_in_if;
    logic          valid;
    logic          ready;
    logic          op;
    tea_pkg::word_t block_high;
    tea_pkg::word_t block_low;

    modport source (output valid, output op, output block_high, output block_low,
                    input ready);
    modport sink   (input valid, input op, input block_high, input block_low,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/tea_out_if.sv -----
`default_nettype none

interface tea_out_if;
    logic          valid;
    logic          ready;
    tea_pkg::word_t result_high;
    tea_pkg::word_t result_low;

    modport source (output valid, output result_high, output result_low, input ready);
    modport sink   (input valid, input result_high, input result_low, output ready);
endinterface

`default_nettype wire

// ----- rtl/tea_block_cipher_enc_dec.sv -----
`default_nettype none

// TEA-style 64-bit block cipher, encrypt or decrypt chosen per beat by op.
// Each half-round has its own register stage, so a block passes 2*ROUNDS
// (64) pipeline stages plus the output register. One block is accepted
// every cycle unless stalled; the pipeline stalls as a whole only
// when its last stage holds a block and the output register holds an untaken
// one. Keys and delta come from the write port, reset to the built-in values,
// and must be written only while no block is in flight.

module tea_block_cipher_enc_dec (
    input  wire logic              clk,
    input  wire logic              rst_n,
    tea_in_if.sink                 in_ch,
    tea_out_if.source              out_ch,
    input  wire logic              cfg_we,
    input  wire tea_pkg::cfg_idx_t cfg_index,
    input  wire tea_pkg::word_t    cfg_data
);

    localparam int STAGES = tea_pkg::STAGES;

    tea_pkg::word_t delta_reg;
    tea_pkg::word_t delta_rounds_reg;
    tea_pkg::word_t k1a_reg;
    tea_pkg::word_t k1b_reg;
    tea_pkg::word_t k2a_reg;
    tea_pkg::word_t k2b_reg;

    logic           valid_reg [STAGES];
    logic           op_reg    [STAGES];
    tea_pkg::word_t hi_reg    [STAGES];
    tea_pkg::word_t lo_reg    [STAGES];
    tea_pkg::word_t sum_reg   [STAGES];

    logic           valid_next [STAGES];
    logic           op_next    [STAGES];
    tea_pkg::word_t hi_next    [STAGES];
    tea_pkg::word_t lo_next    [STAGES];
    tea_pkg::word_t sum_next   [STAGES];

    logic           out_valid_reg;
    tea_pkg::word_t out_hi_reg;
    tea_pkg::word_t out_lo_reg;

    logic advance;

    assign advance = !valid_reg[STAGES-1] || !out_valid_reg || out_ch.ready;
    assign in_ch.ready = advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg        <= tea_pkg::RST_ROUND_DELTA;
            delta_rounds_reg <= tea_pkg::RST_DELTA_ROUNDS;
            k1a_reg          <= tea_pkg::RST_FIRST_KEY_A;
            k1b_reg          <= tea_pkg::RST_FIRST_KEY_B;
            k2a_reg          <= tea_pkg::RST_SECOND_KEY_A;
            k2b_reg          <= tea_pkg::RST_SECOND_KEY_B;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tea_pkg::REG_ROUND_DELTA:
                begin
                    delta_reg        <= cfg_data;
                    delta_rounds_reg <= tea_pkg::WORD_W'(cfg_data *
                                        tea_pkg::word_t'(tea_pkg::ROUNDS));
                end
                tea_pkg::REG_FIRST_KEY_A:  k1a_reg <= cfg_data;
                tea_pkg::REG_FIRST_KEY_B:  k1b_reg <= cfg_data;
                tea_pkg::REG_SECOND_KEY_A: k2a_reg <= cfg_data;
                tea_pkg::REG_SECOND_KEY_B: k2b_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // half-round stages
    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        localparam bit EVEN = (g % 2) == 0;

        logic           s_valid;
        logic           s_op;
        tea_pkg::word_t s_hi;
        tea_pkg::word_t s_lo;
        tea_pkg::word_t s_sum;
        logic           upd_hi;
        tea_pkg::word_t m;

        if (g == 0)
        begin : g_first
            assign s_valid = in_ch.valid;
            assign s_op    = in_ch.op;
            assign s_hi    = in_ch.block_high;
            assign s_lo    = in_ch.block_low;
            assign s_sum   = (in_ch.op == tea_pkg::OP_DECRYPT) ? delta_rounds_reg
                                                               : delta_reg;
        end
        else
        begin : g_rest
            assign s_valid = valid_reg[g-1];
            assign s_op    = op_reg[g-1];
            assign s_hi    = hi_reg[g-1];
            assign s_lo    = lo_reg[g-1];
            assign s_sum   = sum_reg[g-1];
        end

        // encrypt updates high then low, decrypt low then high
        assign upd_hi = EVEN ? (s_op == tea_pkg::OP_ENCRYPT)
                             : (s_op == tea_pkg::OP_DECRYPT);

        always_comb
        begin
            m = upd_hi ? tea_pkg::mix(s_lo, s_sum, k1a_reg, k1b_reg)
                       : tea_pkg::mix(s_hi, s_sum, k2a_reg, k2b_reg);
            valid_next[g] = s_valid;
            op_next[g]    = s_op;
            hi_next[g]    = s_hi;
            lo_next[g]    = s_lo;
            if (upd_hi)
            begin
                hi_next[g] = (s_op == tea_pkg::OP_DECRYPT) ? s_hi - m : s_hi + m;
            end
            else
            begin
                lo_next[g] = (s_op == tea_pkg::OP_DECRYPT) ? s_lo - m : s_lo + m;
            end
            sum_next[g] = s_sum;
            if (!EVEN)
            begin
                sum_next[g] = (s_op == tea_pkg::OP_DECRYPT) ? s_sum - delta_reg
                                                            : s_sum + delta_reg;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[g] <= valid_next[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance && valid_next[g])
            begin
                op_reg[g]  <= op_next[g];
                hi_reg[g]  <= hi_next[g];
                lo_reg[g]  <= lo_next[g];
                sum_reg[g] <= sum_next[g];
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ch.ready)
        begin
            out_valid_reg <= valid_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if ((!out_valid_reg || out_ch.ready) && valid_reg[STAGES-1])
        begin
            out_hi_reg <= hi_reg[STAGES-1];
            out_lo_reg <= lo_reg[STAGES-1];
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.result_high = out_hi_reg;
    assign out_ch.result_low  = out_lo_reg;

    // a stalled pipeline keeps its last stage
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg[STAGES-1]))
        else $error("last stage changed during stall");

    // an accepted beat lands in the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> valid_reg[0])
        else $error("accepted beat lost at pipeline entry");

    // a finished block moves into a free output register
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[STAGES-1] && (!out_valid_reg || out_ch.ready)) |=> out_valid_reg)
        else $error("finished block not moved to output");

endmodule

`default_nettype wire

// ----- sim/tb_tea_block_cipher_enc_dec.sv -----
`timescale 1ns / 1ps

module tb_tea_block_cipher_enc_dec;

    localparam int PIPE_DEPTH  = 2 * tea_pkg::ROUNDS + 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 120;
    localparam tea_pkg::cfg_idx_t IDX_TOP = '1;

    typedef struct packed
    {
        tea_pkg::word_t high;
        tea_pkg::word_t low;
    } block_t;

    class cipher_scoreboard;
        tea_pkg::word_t delta;
        tea_pkg::word_t fka;
        tea_pkg::word_t fkb;
        tea_pkg::word_t ska;
        tea_pkg::word_t skb;
        block_t         expected_q[$];
        int unsigned    blocks_out;
        int unsigned    errors;

        function new();
            delta      = 32'h45AD_9059;
            fka        = 32'hF03E_934F;
            fkb        = 32'h27BD_B886;
            ska        = 32'hD0AA_E945;
            skb        = 32'h993B_A3AE;
            blocks_out = 0;
            errors     = 0;
        endfunction

        function void set_reg(tea_pkg::cfg_idx_t idx, tea_pkg::word_t data);
            case (idx)
                tea_pkg::REG_ROUND_DELTA:  delta = data;
                tea_pkg::REG_FIRST_KEY_A:  fka   = data;
                tea_pkg::REG_FIRST_KEY_B:  fkb   = data;
                tea_pkg::REG_SECOND_KEY_A: ska   = data;
                tea_pkg::REG_SECOND_KEY_B: skb   = data;
                default: ;
            endcase
        endfunction

        function tea_pkg::word_t feistel_term(tea_pkg::word_t v, tea_pkg::word_t s,
                                              tea_pkg::word_t ka, tea_pkg::word_t kb);
            tea_pkg::word_t shl;
            tea_pkg::word_t shr;
            shl = {v[tea_pkg::WORD_W-5:0], 4'b0000};
            shr = {5'b00000, v[tea_pkg::WORD_W-1:5]};
            return (shl + kb) ^ (shr + ka) ^ (v + s);
        endfunction

        function block_t cipher(logic op, tea_pkg::word_t hi, tea_pkg::word_t lo);
            tea_pkg::word_t s;
            block_t         res;
            if (op == tea_pkg::OP_ENCRYPT)
            begin
                s = '0;
                for (int r = 0; r < tea_pkg::ROUNDS; r++)
                begin
                    s  = s + delta;
                    hi = hi + feistel_term(lo, s, fka, fkb);
                    lo = lo + feistel_term(hi, s, ska, skb);
                end
            end
            else
            begin
                s = delta * tea_pkg::word_t'(tea_pkg::ROUNDS);
                for (int r = 0; r < tea_pkg::ROUNDS; r++)
                begin
                    lo = lo - feistel_term(hi, s, ska, skb);
                    hi = hi - feistel_term(lo, s, fka, fkb);
                    s  = s - delta;
                end
            end
            res.high = hi;
            res.low  = lo;
            return res;
        endfunction

        function void note_block(logic op, tea_pkg::word_t hi, tea_pkg::word_t lo);
            expected_q.push_back(cipher(op, hi, lo));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at result %0d: %s", blocks_out, msg);
            errors++;
        endtask

        task check_result(tea_pkg::word_t hi, tea_pkg::word_t lo);
            block_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("no block pending, got %h_%h", hi, lo));
                return;
            end
            want = expected_q.pop_front();
            if (hi !== want.high)
                report_mismatch($sformatf("result_high got %h want %h", hi, want.high));
            if (lo !== want.low)
                report_mismatch($sformatf("result_low got %h want %h", lo, want.low));
            blocks_out++;
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    tea_pkg::cfg_idx_t cfg_index;
    tea_pkg::word_t    cfg_data;
    bit                calm;
    int unsigned       in_beats;
    int unsigned       cycle_count;

    cipher_scoreboard sb = new();

    tea_in_if  in_ch();
    tea_out_if out_ch();

    tea_block_cipher_enc_dec dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // beat monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            begin
                sb.note_block(in_ch.op, in_ch.block_high, in_ch.block_low);
                in_beats++;
            end
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                sb.check_result(out_ch.result_high, out_ch.result_low);
        end
    end

    // result sink with one long hold-off to back up the pipeline
    initial
    begin : sink_proc
        int hold_left;
        bit hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && in_beats >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready = 1'b0;
            end
            else
                out_ch.ready = calm || ($urandom_range(0, 99) >= 21);
        end
    end

    task automatic send_block(input logic op, input tea_pkg::word_t hi,
                              input tea_pkg::word_t lo);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 21)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.op         = op;
        in_ch.block_high = hi;
        in_ch.block_low  = lo;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
    endtask

    task automatic write_reg(input tea_pkg::cfg_idx_t idx, input tea_pkg::word_t data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_keys(input tea_pkg::word_t delta, input tea_pkg::word_t fka,
                              input tea_pkg::word_t fkb, input tea_pkg::word_t ska,
                              input tea_pkg::word_t skb);
        write_reg(tea_pkg::REG_ROUND_DELTA, delta);
        write_reg(tea_pkg::REG_FIRST_KEY_A, fka);
        write_reg(tea_pkg::REG_FIRST_KEY_B, fkb);
        write_reg(tea_pkg::REG_SECOND_KEY_A, ska);
        write_reg(tea_pkg::REG_SECOND_KEY_B, skb);
    endtask

    task automatic settle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    task automatic edge_blocks();
        send_block(tea_pkg::OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(tea_pkg::OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(tea_pkg::OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(tea_pkg::OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(tea_pkg::OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        send_block(tea_pkg::OP_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
    endtask

    task automatic random_blocks(input int count);
        logic           op;
        tea_pkg::word_t hi;
        tea_pkg::word_t lo;
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(0, 1) != 0) ? tea_pkg::OP_DECRYPT : tea_pkg::OP_ENCRYPT;
            hi = $urandom;
            lo = $urandom;
            case ($urandom_range(0, 15))
                0: hi = '0;
                1: hi = '1;
                2: lo = '0;
                3: lo = '1;
                default: ;
            endcase
            send_block(op, hi, lo);
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = tea_pkg::REG_ROUND_DELTA;
        cfg_data         = '0;
        calm             = 1'b0;
        in_beats         = 0;
        in_ch.valid      = 1'b0;
        in_ch.op         = tea_pkg::OP_ENCRYPT;
        in_ch.block_high = '0;
        in_ch.block_low  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset keys
        edge_blocks();
        random_blocks(160);
        settle();

        // all-zero keys and delta
        write_keys('0, '0, '0, '0, '0);
        edge_blocks();
        random_blocks(80);
        settle();

        // all-ones keys and delta, back-to-back beats
        write_keys('1, '1, '1, '1, '1);
        calm = 1'b1;
        edge_blocks();
        random_blocks(80);
        settle();
        calm = 1'b0;

        // random keys, then writes to unused indexes that must be dropped
        write_keys($urandom, $urandom, $urandom, $urandom, $urandom);
        for (int i = int'(tea_pkg::REG_SECOND_KEY_B) + 1; i <= int'(IDX_TOP); i++)
            write_reg(tea_pkg::cfg_idx_t'(i), $urandom);
        random_blocks(130);
        settle();

        // delta whose round multiple wraps to zero
        write_keys(32'h8000_0000, $urandom, $urandom, $urandom, $urandom);
        random_blocks(130);
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tea_pkg.sv
rtl/tea_in_if.sv
rtl/tea_out_if.sv
rtl/tea_block_cipher_enc_dec.sv
sim/tb_tea_block_cipher_enc_dec.sv
